>>> rtl/rrpa_pkg.sv
// ----------------------------------------------------------------------------
// rrpa_pkg: shared definitions for the round-robin pull arbiter
// Operation codes, fixed field widths and the command bundle that the
// controller hands to the datapath.
// ----------------------------------------------------------------------------
package rrpa_pkg;

   // Default number of upstream sources.
   localparam int DEFAULT_NUM_SOURCES = 8;

   // Fixed widths of the transaction fields.
   localparam int READY_MASK_W = 8;
   localparam int INDEX_W      = 3;

   // Operation codes carried in the op field.
   localparam logic OP_PULL    = 1'b0;
   localparam logic OP_UNBLOCK = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the incoming transaction into the item register
      logic execute;   // evaluate the held item, update state, load the result
   } dp_cmd_type;

endpackage

>>> rtl/round_robin_pull_arbiter.sv
// ----------------------------------------------------------------------------
// round_robin_pull_arbiter: round-robin pull arbiter over upstream sources
// Each pull transaction walks the sources from the rotating pointer, blocks
// the unblocked sources without data that it passes, and grants the first one that has
// data. Unblock transactions clear one blocked mark and wake a pending pull.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_op, req_ready_mask,
//                                               req_unblock_index
//   rsp_      out        rsp_valid / rsp_stall  rsp_grant_valid, rsp_grant_index,
//                                               rsp_underrun, rsp_wake
//
// Every transaction passes through two steps: capture into the item
// register, then, once the result register is free, the rotating priority
// search that updates the state and the result register. The two-state
// controller sequences these steps. The result register parts the two sides,
// so a new transaction is accepted while a finished result still waits under
// rsp_stall; the search stage then waits until the result register drains.
// Reset is synchronous and active high; it clears all blocked marks, the
// pending-pull flag, and points the search at source 0.
//
// Each transaction yields exactly one result. A pull result carries either a
// grant with the source index or an underrun; an unblock result carries only
// the wake bit. The pointer moves to the source just past the grant, or just
// past the last source that blocked in an underrun walk; it stays if all were blocked.
// ----------------------------------------------------------------------------
module round_robin_pull_arbiter #(
   parameter int NUM_SOURCES = rrpa_pkg::DEFAULT_NUM_SOURCES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [rrpa_pkg::READY_MASK_W-1:0] req_ready_mask,
   input  logic [rrpa_pkg::INDEX_W-1:0]      req_unblock_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_grant_valid,
   output logic [rrpa_pkg::INDEX_W-1:0]      rsp_grant_index,
   output logic                              rsp_underrun,
   output logic                              rsp_wake
);
   import rrpa_pkg::*;

   // Command bundle from the controller to the datapath.
   dp_cmd_type cmd;

   // The controller owns both handshakes and decides when the datapath
   // captures a transaction and when it evaluates it.
   rrpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // The datapath holds the arbitration state and the result register.
   rrpa_datapath #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_op            (req_op),
      .req_ready_mask    (req_ready_mask),
      .req_unblock_index (req_unblock_index),
      .rsp_grant_valid   (rsp_grant_valid),
      .rsp_grant_index   (rsp_grant_index),
      .rsp_underrun      (rsp_underrun),
      .rsp_wake          (rsp_wake)
   );

endmodule

>>> rtl/rrpa_ctrl.sv
// ----------------------------------------------------------------------------
// rrpa_ctrl: handshake controller
// Two-state sequencer that accepts one transaction, then fires the datapath
// once the result register is free, and tracks the result valid flag.
// ----------------------------------------------------------------------------
module rrpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rrpa_pkg::dp_cmd_type cmd
);
   import rrpa_pkg::*;

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_EXEC = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       out_free;
   logic       fire;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // The result register can be loaded when it is empty or drains this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = (state_ff == ST_EXEC) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = accept;
   assign cmd.execute = fire;

endmodule

>>> rtl/rrpa_datapath.sv
// ----------------------------------------------------------------------------
// rrpa_datapath: arbitration state and rotating priority search
// Holds the blocked marks, the rotating pointer, the pending-pull flag, the
// item register and the result register.
// ----------------------------------------------------------------------------
module rrpa_datapath #(
   parameter int NUM_SOURCES = rrpa_pkg::DEFAULT_NUM_SOURCES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rrpa_pkg::dp_cmd_type             cmd,
   input  logic                             req_op,
   input  logic [rrpa_pkg::READY_MASK_W-1:0] req_ready_mask,
   input  logic [rrpa_pkg::INDEX_W-1:0]      req_unblock_index,
   output logic                             rsp_grant_valid,
   output logic [rrpa_pkg::INDEX_W-1:0]      rsp_grant_index,
   output logic                             rsp_underrun,
   output logic                             rsp_wake
);
   import rrpa_pkg::*;

   localparam int PTR_W = $clog2(NUM_SOURCES);
   localparam int SUM_W = PTR_W + 1;
   localparam logic [SUM_W-1:0] N_SUM = SUM_W'(NUM_SOURCES);

   // Reduce a value below twice the source count into the source range.
   function automatic logic [PTR_W-1:0] wrap_src(input logic [SUM_W-1:0] value);
      logic [SUM_W-1:0] reduced;
      reduced = (value >= N_SUM) ? (value - N_SUM) : value;
      return reduced[PTR_W-1:0];
   endfunction

   // Item register.
   logic                    op_ff;
   logic [READY_MASK_W-1:0] ready_ff;
   logic [INDEX_W-1:0]      uidx_ff;

   // Arbitration state.
   logic [NUM_SOURCES-1:0] blocked_ff;
   logic [NUM_SOURCES-1:0] blocked_in;
   logic [PTR_W-1:0]       pointer_ff;
   logic [PTR_W-1:0]       pointer_in;
   logic                   pending_ff;
   logic                   pending_in;

   // Result register.
   logic               grant_valid_ff;
   logic               grant_valid_in;
   logic [INDEX_W-1:0] grant_index_ff;
   logic [INDEX_W-1:0] grant_index_in;
   logic               underrun_ff;
   logic               underrun_in;
   logic               wake_ff;
   logic               wake_in;

   // Search signals.
   logic [NUM_SOURCES-1:0] ready_ext;
   logic [NUM_SOURCES-1:0] unblocked;
   logic [NUM_SOURCES-1:0] cand;
   logic [NUM_SOURCES-1:0] cand_rot;
   logic [NUM_SOURCES-1:0] unb_rot;
   logic [NUM_SOURCES-1:0] first_rot;
   logic [NUM_SOURCES-1:0] below_rot;
   logic [NUM_SOURCES-1:0] newblk_rot;
   logic [NUM_SOURCES-1:0] first_src;
   logic [NUM_SOURCES-1:0] newblk_src;
   logic [PTR_W-1:0]       rot_src [NUM_SOURCES];
   logic [PTR_W-1:0]       src_rot [NUM_SOURCES];
   logic [PTR_W-1:0]       grant_src;
   logic [PTR_W-1:0]       last_off;
   logic [PTR_W-1:0]       last_src;
   logic                   all_blocked;
   logic                   any_cand;

   // Sources beyond the ready mask never have data.
   for (genvar s = 0; s < NUM_SOURCES; s++) begin : g_ready
      if (s < READY_MASK_W) begin : g_bit
         assign ready_ext[s] = ready_ff[s];
      end else begin : g_none
         assign ready_ext[s] = 1'b0;
      end
   end

   assign unblocked   = ~blocked_ff;
   assign cand        = unblocked & ready_ext;
   assign all_blocked = &blocked_ff;
   assign any_cand    = |cand;

   // Rotation maps: rotated offset i looks at source pointer+i, and source s
   // sits at rotated offset s-pointer.
   for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_rot
      assign rot_src[i] = wrap_src(SUM_W'(pointer_ff) + SUM_W'(i));
      assign src_rot[i] = wrap_src(SUM_W'(i) + N_SUM - SUM_W'(pointer_ff));
      assign cand_rot[i]   = cand[rot_src[i]];
      assign unb_rot[i]    = unblocked[rot_src[i]];
      assign first_src[i]  = first_rot[src_rot[i]];
      assign newblk_src[i] = newblk_rot[src_rot[i]];
   end

   // Lowest set candidate in rotated order; everything before it is an
   // unblocked source without data and becomes blocked. With no candidate the
   // mask below covers all sources.
   assign first_rot  = cand_rot & (~cand_rot + NUM_SOURCES'(1));
   assign below_rot  = first_rot - NUM_SOURCES'(1);
   assign newblk_rot = unb_rot & below_rot;

   always_comb begin
      grant_src = '0;
      last_off  = '0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
         if (first_src[s]) begin
            grant_src = grant_src | PTR_W'(s);
         end
         if (unb_rot[s]) begin
            last_off = PTR_W'(s);
         end
      end
   end

   assign last_src = rot_src[last_off];

   always_comb begin
      blocked_in     = blocked_ff;
      pointer_in     = pointer_ff;
      pending_in     = pending_ff;
      grant_valid_in = 1'b0;
      grant_index_in = '0;
      underrun_in    = 1'b0;
      wake_in        = 1'b0;
      if (op_ff == OP_UNBLOCK) begin
         for (int s = 0; s < NUM_SOURCES; s++) begin
            if (32'(uidx_ff) == s) begin
               blocked_in[s] = 1'b0;
            end
         end
         wake_in    = pending_ff;
         pending_in = 1'b0;
      end else if (all_blocked) begin
         underrun_in = 1'b1;
         pending_in  = 1'b1;
      end else if (any_cand) begin
         blocked_in     = blocked_ff | newblk_src;
         grant_valid_in = 1'b1;
         grant_index_in = INDEX_W'(grant_src);
         pointer_in     = wrap_src(SUM_W'(grant_src) + SUM_W'(1));
      end else begin
         // Every remaining source blocks during the walk.
         blocked_in  = '1;
         underrun_in = 1'b1;
         pending_in  = 1'b1;
         pointer_in  = wrap_src(SUM_W'(last_src) + SUM_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         ready_ff <= req_ready_mask;
         uidx_ff  <= req_unblock_index;
      end
      if (cmd.execute) begin
         grant_valid_ff <= grant_valid_in;
         grant_index_ff <= grant_index_in;
         underrun_ff    <= underrun_in;
         wake_ff        <= wake_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= '0;
         pointer_ff <= '0;
         pending_ff <= 1'b0;
      end else if (cmd.execute) begin
         blocked_ff <= blocked_in;
         pointer_ff <= pointer_in;
         pending_ff <= pending_in;
      end
   end

   assign rsp_grant_valid = grant_valid_ff;
   assign rsp_grant_index = grant_index_ff;
   assign rsp_underrun    = underrun_ff;
   assign rsp_wake        = wake_ff;

   // A pending pull can only exist while every source is blocked.
   a_pending_all_blocked: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> all_blocked)
      else $error("pull pending while some source is unblocked");

   // An underrun result leaves every source blocked and a pull pending.
   a_underrun_state: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (!underrun_ff || (pending_ff && all_blocked)))
      else $error("underrun reported without full blocking");

   // A grant and an underrun never come from the same transaction.
   a_grant_xor_underrun: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> !(grant_valid_ff && underrun_ff))
      else $error("grant and underrun in one result");

   // A wake always releases the pending pull.
   a_wake_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (!wake_ff || !pending_ff))
      else $error("wake left a pull pending");

endmodule
